FILE: src/fvc_pkg.sv
`default_nettype none

package fvc_pkg;

  // coefficient format and register layout
  localparam int COEF_W        = 16;
  localparam int NUM_COEF_REGS = 3;
  localparam int COEFS_PER_REG = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int TAP_W         = 4;
  localparam int RESULT_W      = 32;
  localparam int GROUP_SIZE    = 4;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TAP_COUNT = 2'd0,
    CFG_COEF_0_3  = 2'd1,
    CFG_COEF_4_7  = 2'd2,
    CFG_COEF_8_11 = 2'd3
  } cfg_reg_t;

  // control that travels with a beat down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctrl_t;

endpackage

`default_nettype wire

FILE: src/fvc_cell.sv
`default_nettype none

module fvc_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          shift,
  input  wire logic                                          advance,
  input  wire logic signed [SAMPLE_BITS-1:0]                 sample_in,
  input  wire logic signed [fvc_pkg::COEF_W-1:0]             coef,
  output logic signed [SAMPLE_BITS-1:0]                      sample_out,
  output logic signed [SAMPLE_BITS+fvc_pkg::COEF_W-1:0]      product
);
  import fvc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] sample_q;

  // delay line stage: take the neighbor's sample on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_q <= '0;
    end else if (shift) begin
      sample_q <= sample_in;
    end
  end

  // tap product, one register per cell
  always_ff @(posedge clk) begin
    if (advance) begin
      product <= sample_q * coef;
    end
  end

  assign sample_out = sample_q;

endmodule

`default_nettype wire

FILE: src/fvc_sum.sv
`default_nettype none

module fvc_sum #(
  parameter int MAX_TAPS  = 10,
  parameter int PROD_W    = 32,
  parameter int ACC_W     = 36,
  parameter int FRAC_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire fvc_pkg::beat_ctrl_t               ctrl_in,
  input  wire logic signed [PROD_W-1:0]          products [MAX_TAPS],
  output logic                                   result_valid,
  output logic                                   result_last,
  output logic signed [fvc_pkg::RESULT_W-1:0]    result_value
);
  import fvc_pkg::*;

  localparam int NUM_GROUPS = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int QW         = ACC_W - FRAC_BITS;

  beat_ctrl_t               ctrl_prod;
  beat_ctrl_t               ctrl_group;
  beat_ctrl_t               ctrl_total;
  logic signed [ACC_W-1:0]  group_sum      [NUM_GROUPS];
  logic signed [ACC_W-1:0]  group_sum_next [NUM_GROUPS];
  logic signed [ACC_W-1:0]  total;
  logic signed [ACC_W-1:0]  total_next;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [QW-1:0]     quotient;
  logic signed [RESULT_W-1:0] result_next;

  // control pipeline, in step with the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_prod    <= '0;
      ctrl_group   <= '0;
      ctrl_total   <= '0;
      result_valid <= 1'b0;
      result_last  <= 1'b0;
    end else if (advance) begin
      ctrl_prod    <= ctrl_in;
      ctrl_group   <= ctrl_prod;
      ctrl_total   <= ctrl_group;
      result_valid <= ctrl_total.valid;
      result_last  <= ctrl_total.last;
    end
  end

  // first tree level: products summed in groups of four
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_sum_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < MAX_TAPS) begin
          group_sum_next[g] = group_sum_next[g]
                              + ACC_W'(products[g * GROUP_SIZE + k]);
        end
      end
    end
  end

  // second tree level: group sums added up
  always_comb begin
    total_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total_next = total_next + group_sum[g];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      group_sum <= group_sum_next;
      total     <= total_next;
    end
  end

  // drop fraction bits, truncating toward zero
  always_comb begin
    rounded  = total + (total[ACC_W-1] ? ACC_W'((2 ** FRAC_BITS) - 1) : ACC_W'(0));
    quotient = rounded[ACC_W-1:FRAC_BITS];
  end

  // clamp to the 32-bit signed range
  generate
    if (QW > RESULT_W) begin : g_sat
      always_comb begin
        if (&quotient[QW-1:RESULT_W-1] || ~|quotient[QW-1:RESULT_W-1]) begin
          result_next = quotient[RESULT_W-1:0];
        end else if (quotient[QW-1]) begin
          result_next = {1'b1, {(RESULT_W-1){1'b0}}};
        end else begin
          result_next = {1'b0, {(RESULT_W-1){1'b1}}};
        end
      end
    end else begin : g_ext
      always_comb begin
        result_next = RESULT_W'(quotient);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (advance) begin
      result_value <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/fir_valid_correlation.sv
`default_nettype none

// channel  | beat fields (tdata low bit up)             | side bits
// ---------+---------------------------------------------+---------------------------------
// s_*      | sample (SAMPLE_BITS, signed, zero padded)   | tuser first_of_block, tlast last
// m_*      | result_value (32, signed)                   | tlast last_result
// cfg_*    | cfg_index register index, cfg_data value    | -
//
// Sustains one sample per clock while m_* is not stalled. A sample that yields a result
// appears at m_* once its beat, which the delay line cell takes, has passed the tap
// multiply, group adders, final adder and output register. The pipeline moves as one,
// so an output stall holds s_tready low.
// rst is synchronous: tap_count goes to 1, coefficients, delay line and fill count to zero.
// cfg_ready is always high; the user must write configuration only while the pipeline is empty (not enforced).

module fir_valid_correlation #(
  parameter int MAX_TAPS       = 10,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // sample stream
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample
  input  wire logic                                   s_tuser,   // first_of_block
  input  wire logic                                   s_tlast,
  // result stream
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [fvc_pkg::RESULT_W-1:0]                m_tdata,   // result_value
  output logic                                        m_tlast,
  // configuration writes
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [fvc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [fvc_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import fvc_pkg::*;

  localparam int PROD_W   = SAMPLE_BITS + COEF_W;
  localparam int ACC_W    = PROD_W + 4;
  localparam int NUM_COEF = NUM_COEF_REGS * COEFS_PER_REG;

  logic                          advance;
  logic                          accept;
  logic [TAP_W-1:0]              tap_count;
  logic [CFG_DATA_W-1:0]         coef_reg  [NUM_COEF_REGS];
  logic [TAP_W-1:0]              taps;
  logic signed [COEF_W-1:0]      coef_tab  [NUM_COEF];
  logic signed [COEF_W-1:0]      cell_coef [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] cell_sample [MAX_TAPS];
  logic signed [PROD_W-1:0]      products  [MAX_TAPS];
  logic [TAP_W-1:0]              fill_count;
  logic [TAP_W-1:0]              fill_base;
  logic [TAP_W-1:0]              fill_count_next;
  logic                          emit;
  beat_ctrl_t                    ctrl_cell;
  logic signed [RESULT_W-1:0]    result_value;

  // pipeline moves whenever the output register is free
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_W'(1);
      for (int r = 0; r < NUM_COEF_REGS; r++) begin
        coef_reg[r] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TAP_COUNT: tap_count   <= cfg_data[TAP_W-1:0];
        CFG_COEF_0_3:  coef_reg[0] <= cfg_data;
        CFG_COEF_4_7:  coef_reg[1] <= cfg_data;
        CFG_COEF_8_11: coef_reg[2] <= cfg_data;
      endcase
    end
  end

  // taps in use, clamped to 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      taps = TAP_W'(1);
    end else if (tap_count > TAP_W'(MAX_TAPS)) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = tap_count;
    end
  end

  // unpack coefficient registers
  always_comb begin
    for (int r = 0; r < NUM_COEF_REGS; r++) begin
      for (int k = 0; k < COEFS_PER_REG; k++) begin
        coef_tab[r * COEFS_PER_REG + k] = coef_reg[r][k * COEF_W +: COEF_W];
      end
    end
  end

  // window fill count and result decision
  always_comb begin
    fill_base       = s_tuser ? '0 : fill_count;
    fill_count_next = (fill_base < TAP_W'(MAX_TAPS)) ? fill_base + TAP_W'(1) : fill_base;
    emit            = fill_count_next >= taps;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      ctrl_cell  <= '0;
    end else if (advance) begin
      ctrl_cell.valid <= accept && emit;
      ctrl_cell.last  <= s_tlast;
      if (accept) begin
        fill_count <= fill_count_next;
      end
    end
  end

  // row of cells: cell 0 holds the newest sample and takes coef[taps-1]
  generate
    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      always_comb begin
        if (TAP_W'(i) < taps) begin
          cell_coef[i] = coef_tab[taps - TAP_W'(i) - TAP_W'(1)];
        end else begin
          cell_coef[i] = '0;
        end
      end

      if (i == 0) begin : g_head
        fvc_cell #(
          .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
          .clk        (clk),
          .rst        (rst),
          .shift      (accept),
          .advance    (advance),
          .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
          .coef       (cell_coef[i]),
          .sample_out (cell_sample[i]),
          .product    (products[i])
        );
      end else begin : g_body
        fvc_cell #(
          .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
          .clk        (clk),
          .rst        (rst),
          .shift      (accept),
          .advance    (advance),
          .sample_in  (cell_sample[i-1]),
          .coef       (cell_coef[i]),
          .sample_out (cell_sample[i]),
          .product    (products[i])
        );
      end
    end
  endgenerate

  // adder tree, truncation and output register
  fvc_sum #(
    .MAX_TAPS  (MAX_TAPS),
    .PROD_W    (PROD_W),
    .ACC_W     (ACC_W),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_sum (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .ctrl_in      (ctrl_cell),
    .products     (products),
    .result_valid (m_tvalid),
    .result_last  (m_tlast),
    .result_value (result_value)
  );

  assign m_tdata = result_value;

endmodule

`default_nettype wire

FILE: bench/correlation_checker.sv
`timescale 1ns / 100ps

module correlation_checker #(
  parameter int MAX_TAPS       = 10,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 12,
  parameter int TDATA_W        = ((SAMPLE_BITS+7)/8)*8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // sample stream
  input  wire logic                              s_tvalid,
  input  wire logic                              s_tready,
  input  wire logic [TDATA_W-1:0]                s_tdata,   // sample
  input  wire logic                              s_tuser,   // first_of_block
  input  wire logic                              s_tlast,
  // result stream
  input  wire logic                              m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic [fvc_pkg::RESULT_W-1:0]      m_tdata,   // result_value
  input  wire logic                              m_tlast,
  // configuration writes
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [fvc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fvc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // status toward the bench
  output int                                     failures,
  output int                                     outstanding,
  output int                                     checked
);
  import fvc_pkg::*;

  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    logic                       last;
  } fir_result_t;

  // shadow of the block's registers and delay line
  logic [TAP_W-1:0]              tap_reg;
  logic [CFG_DATA_W-1:0]         coef_bank [NUM_COEF_REGS];
  logic signed [SAMPLE_BITS-1:0] delay_line [MAX_TAPS];  // index 0 newest
  int                            fill;
  fir_result_t                   expected_sums [$];
  int                            fail_cnt = 0;
  int                            check_cnt = 0;

  function automatic logic signed [COEF_W-1:0] coef_at(int tap);
    logic [CFG_DATA_W-1:0] word;
    word = coef_bank[tap / COEFS_PER_REG];
    return word[(tap % COEFS_PER_REG) * COEF_W +: COEF_W];
  endfunction

  // shift one sample in and queue the window sum once the block is warm
  function automatic void filter_sample(logic signed [SAMPLE_BITS-1:0] smp,
                                        logic first, logic last);
    int                 taps;
    int                 j;
    logic signed [63:0] acc;
    logic signed [63:0] c;
    logic signed [63:0] w;
    logic [63:0]        mag;
    fir_result_t        r;
    taps = (tap_reg == 0) ? 1 : ((tap_reg > MAX_TAPS) ? MAX_TAPS : int'(tap_reg));
    if (first) fill = 0;
    for (j = MAX_TAPS - 1; j > 0; j--) delay_line[j] = delay_line[j-1];
    delay_line[0] = smp;
    if (fill < MAX_TAPS) fill++;
    if (fill < taps) return;
    acc = 0;
    for (j = 0; j < taps; j++) begin
      c = coef_at(j);
      w = delay_line[taps-1-j];
      acc = acc + c * w;
    end
    // drop the fraction toward zero, clamp to the result range
    if (acc < 0) begin
      mag = -acc;
      mag = mag >> COEF_FRAC_BITS;
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      r.value = -mag[RESULT_W-1:0];
    end else begin
      mag = acc;
      mag = mag >> COEF_FRAC_BITS;
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      r.value = mag[RESULT_W-1:0];
    end
    r.last = last;
    expected_sums.push_back(r);
  endfunction

  always @(posedge clk) begin
    fir_result_t got;
    fir_result_t want;
    if (rst) begin
      tap_reg = 1;
      for (int i = 0; i < NUM_COEF_REGS; i++) coef_bank[i] = '0;
      for (int i = 0; i < MAX_TAPS; i++) delay_line[i] = '0;
      fill = 0;
      expected_sums.delete();
    end else begin
      // result beat against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.value = m_tdata;
        got.last  = m_tlast;
        if (expected_sums.size() == 0) begin
          $error("result beat with nothing expected: result_value %0d, last_result %0b",
                 got.value, got.last);
          fail_cnt++;
        end else begin
          want = expected_sums.pop_front();
          check_cnt++;
          if (got.value !== want.value) begin
            $error("result_value mismatch: expected %0d, actual %0d", want.value, got.value);
            fail_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last_result mismatch: expected %0b, actual %0b", want.last, got.last);
            fail_cnt++;
          end
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TAP_COUNT: tap_reg = cfg_data[TAP_W-1:0];
          CFG_COEF_0_3:  coef_bank[0] = cfg_data;
          CFG_COEF_4_7:  coef_bank[1] = cfg_data;
          CFG_COEF_8_11: coef_bank[2] = cfg_data;
          default: ;
        endcase
      end
      // sample beat
      if (s_tvalid && s_tready) filter_sample(s_tdata[SAMPLE_BITS-1:0], s_tuser, s_tlast);
    end
    failures    <= fail_cnt;
    outstanding <= expected_sums.size();
    checked     <= check_cnt;
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fvc_pkg::*;

  localparam int MAX_TAPS       = 10;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 12;
  localparam int TDATA_W        = ((SAMPLE_BITS+7)/8)*8;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int HOLD_CYCLES    = 120;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 48;
  localparam int HOLD_PHASE     = 3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata;   // sample
  logic                   s_tuser;   // first_of_block
  logic                   s_tlast;   // last_sample
  logic                   m_tvalid;
  logic                   m_tready;
  logic [RESULT_W-1:0]    m_tdata;   // result_value
  logic                   m_tlast;   // last_result
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int failures;
  int outstanding;
  int checked;
  int cycle_count = 0;
  int samples_sent = 0;
  int settings_used = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  fir_valid_correlation #(
    .MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  correlation_checker #(
    .MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) result_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding), .checked(checked)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  // one sample beat; entered and left at a falling edge
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                             input logic first, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'($unsigned(smp));
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
    @(negedge clk);
  endtask

  // one register write beat; caller drops cfg_valid after the last one
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [TAP_W-1:0] taps, input logic [CFG_DATA_W-1:0] c0,
                            input logic [CFG_DATA_W-1:0] c1, input logic [CFG_DATA_W-1:0] c2);
    write_reg(CFG_TAP_COUNT, CFG_DATA_W'(taps));
    write_reg(CFG_COEF_0_3, c0);
    write_reg(CFG_COEF_4_7, c1);
    write_reg(CFG_COEF_8_11, c2);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // stop offering, let every owed result out, then let the pipeline empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return SAMPLE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coef_reg();
    logic [CFG_DATA_W-1:0] r;
    for (int i = 0; i < COEFS_PER_REG; i++) begin
      case ($urandom_range(0, 5))
        0:       r[i*COEF_W +: COEF_W] = 16'h7FFF;
        1:       r[i*COEF_W +: COEF_W] = 16'h8000;
        2:       r[i*COEF_W +: COEF_W] = 16'h0000;
        3:       r[i*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 8191)) - 16'd4096;
        default: r[i*COEF_W +: COEF_W] = COEF_W'($urandom);
      endcase
    end
    return r;
  endfunction

  // blocks of random length, mostly well formed; the last block is cut to the phase size
  task automatic run_phase(input int n_items, input int eff);
    int   sent;
    int   len;
    int   kind;
    int   k;
    logic first;
    logic last;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) len = $urandom_range(1, (eff > 1) ? eff - 1 : 1);
      else len = $urandom_range(eff, eff + 24);
      if (len > n_items - sent) len = n_items - sent;
      for (k = 0; k < len; k++) begin
        first = (k == 0) && (kind != 1);
        last  = (k == len - 1);
        // noise: flags at random
        if (kind == 2) begin
          first = ($urandom_range(0, 3) == 0);
          last  = ($urandom_range(0, 3) == 0);
        end
        send_sample(pick_sample(), first, last);
        sent++;
      end
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    logic [TAP_W-1:0] taps;
    int               eff;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TAP_COUNT;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: one tap, zero coefficients
    settings_used = 1;
    send_sample(16'h7FFF, 1'b1, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b1);

    // three taps; short block, then the window carries on past its last sample
    wait_idle();
    set_config(4'd3, 64'h0000_1000_8000_7FFF, '0, '0);
    send_sample(16'sd100, 1'b1, 1'b0);
    send_sample(-16'sd5, 1'b0, 1'b1);
    send_sample(16'h7FFF, 1'b0, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b1);

    // tap count zero acts as one; small negative coefficient rounds toward zero
    wait_idle();
    set_config(4'd0, 64'h0000_0000_0000_FFFF, '0, '0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'h0001, 1'b0, 0);
    send_sample(16'h7FFF, 1'b0, 1'b1);

    // tap count above the maximum; largest sum; unused slots hold junk
    wait_idle();
    set_config(4'd15, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
               64'h7FFF_1234_8000_8000);
    for (int k = 0; k < MAX_TAPS; k++) send_sample(16'h8000, k == 0, k == MAX_TAPS - 1);

    // tap count lowered in the middle of a block
    wait_idle();
    set_config(4'd4, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
               64'h7FFF_1234_8000_8000);
    send_sample(16'h7FFF, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b0, 1'b1);

    // random phases, each with its own setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0:          taps = 4'd1;
        1:          taps = 4'd10;
        2:          taps = 4'd0;
        HOLD_PHASE: taps = 4'd15;
        default:    taps = ($urandom_range(0, 4) == 0) ? TAP_W'($urandom_range(0, 15))
                                                       : TAP_W'($urandom_range(1, 10));
      endcase
      eff = (taps == 0) ? 1 : ((taps > MAX_TAPS) ? MAX_TAPS : int'(taps));
      set_config(taps, rand_coef_reg(), rand_coef_reg(), rand_coef_reg());
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (p == HOLD_PHASE) begin
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      run_phase(PHASE_ITEMS, eff);
    end

    wait_idle();
    $display("covered %0d samples under %0d register settings, %0d results compared",
             samples_sent, settings_used, checked);
    $display("tap counts 0 to 15, short and continued blocks, mid-block change, long stall");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/fvc_pkg.sv
src/fvc_cell.sv
src/fvc_sum.sv
src/fir_valid_correlation.sv
bench/correlation_checker.sv
bench/tb_top.sv
